FILE: rtl/core/operand_address_mode_resolver_core_defines.svh
// ----------------------------------------------------------------------------
// Operand address mode resolver: assertion macros
// Clocked assertion helpers; they expand to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef OPERAND_ADDRESS_MODE_RESOLVER_CORE_DEFINES_SVH
`define OPERAND_ADDRESS_MODE_RESOLVER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

`define OAMR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define OAMR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define OAMR_ASSERT(lbl, clk, rst_n, prop, msg)

`define OAMR_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

FILE: rtl/core/oamr_pkg.sv
// ----------------------------------------------------------------------------
// Operand address mode resolver package
// Command and mode codes, register numbers and controller/datapath types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package oamr_pkg;

    localparam int unsigned MEM_WORDS_DEF = 32768;

    localparam logic [2:0] PC_REG = 3'd7;
    localparam logic [2:0] SP_REG = 3'd6;

    localparam logic [1:0] CMD_MEM_WR  = 2'd0;
    localparam logic [1:0] CMD_REG_WR  = 2'd1;
    localparam logic [1:0] CMD_RESOLVE = 2'd2;

    localparam logic [2:0] MODE_REG           = 3'd0;
    localparam logic [2:0] MODE_DEFER         = 3'd1;
    localparam logic [2:0] MODE_AUTOINC       = 3'd2;
    localparam logic [2:0] MODE_AUTOINC_DEFER = 3'd3;
    localparam logic [2:0] MODE_INDEX         = 3'd6;

    typedef enum logic [1:0] {
        RD_REG,
        RD_PC,
        RD_DATA,
        RD_SUM
    } t_rd_sel;

    typedef enum logic [1:0] {
        EA_REG,
        EA_DATA,
        EA_SUM
    } t_ea_sel;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_AUTO,
        UPD_TWO_R,
        UPD_TWO_PC
    } t_upd_sel;

    typedef enum logic [1:0] {
        OUT_REG,
        OUT_MEM,
        OUT_UNSUP
    } t_out_sel;

    typedef struct packed {
        logic     capture;
        logic     mem_wr;
        logic     reg_wr;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     ea_load;
        t_ea_sel  ea_sel;
        t_upd_sel upd;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] mode;
    } t_dp_stat;

endpackage

FILE: rtl/core/oamr_datapath.sv
// ----------------------------------------------------------------------------
// Operand address mode resolver datapath
// Register file, word memory with registered read, address arithmetic
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module oamr_datapath #(
    parameter int unsigned MEM_WORDS = oamr_pkg::MEM_WORDS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  oamr_pkg::t_dp_cmd  i_cmd,
    output oamr_pkg::t_dp_stat o_stat,
    input  logic [5:0]         i_specifier,
    input  logic               i_byte_mode,
    input  logic [15:0]        i_load_address,
    input  logic [2:0]         i_load_register,
    input  logic [15:0]        i_load_data,
    output logic [15:0]        o_operand_address,
    output logic [15:0]        o_operand_value,
    output logic               o_status
);
    import oamr_pkg::*;

    localparam int unsigned AW      = $clog2(MEM_WORDS);
    localparam logic [15:0] MEM_LIM = 16'(MEM_WORDS);

    logic [15:0] mem_array [MEM_WORDS];
    logic [15:0] r_regs [8];

    logic [5:0]  r_spec;
    logic        r_byte;
    logic [15:0] r_rdata;
    logic        r_rd_oob;
    logic [15:0] r_eaddr;
    logic [15:0] r_op_addr;
    logic [15:0] r_op_val;
    logic        r_status;

    logic [2:0]    reg_idx;
    logic [15:0]   reg_val;
    logic [15:0]   pc_val;
    logic [15:0]   mem_data;
    logic [15:0]   sum;
    logic [15:0]   rd_addr;
    logic          rd_oob;
    logic          wr_oob;
    logic [AW-1:0] rd_idx;
    logic [AW-1:0] wr_idx;
    logic [15:0]   inc;

    assign reg_idx  = r_spec[2:0];
    assign reg_val  = r_regs[reg_idx];
    assign pc_val   = r_regs[PC_REG];
    assign mem_data = r_rd_oob ? 16'd0 : r_rdata;
    assign sum      = reg_val + mem_data;

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_REG:  rd_addr = reg_val;
            RD_PC:   rd_addr = pc_val;
            RD_DATA: rd_addr = mem_data;
            RD_SUM:  rd_addr = sum;
            default: rd_addr = reg_val;
        endcase
    end

    assign rd_oob = {1'b0, rd_addr[15:1]} >= MEM_LIM;
    assign wr_oob = {1'b0, i_load_address[15:1]} >= MEM_LIM;
    assign rd_idx = rd_addr[AW:1];
    assign wr_idx = i_load_address[AW:1];

    assign inc = (r_byte && reg_idx != SP_REG && reg_idx != PC_REG) ? 16'd1 : 16'd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_regs[i] <= 16'd0;
            end
        end else if (i_cmd.reg_wr) begin
            r_regs[i_load_register] <= i_load_data;
        end else begin
            unique case (i_cmd.upd)
                UPD_NONE:   ;
                UPD_AUTO:   r_regs[reg_idx] <= reg_val + inc;
                UPD_TWO_R:  r_regs[reg_idx] <= reg_val + 16'd2;
                UPD_TWO_PC: r_regs[PC_REG]  <= pc_val + 16'd2;
                default:    ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_wr && !wr_oob) begin
            mem_array[wr_idx] <= i_load_data;
        end
        if (i_cmd.rd_en) begin
            r_rdata  <= mem_array[rd_idx];
            r_rd_oob <= rd_oob;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_spec <= i_specifier;
            r_byte <= i_byte_mode;
        end
        if (i_cmd.ea_load) begin
            unique case (i_cmd.ea_sel)
                EA_REG:  r_eaddr <= reg_val;
                EA_DATA: r_eaddr <= mem_data;
                EA_SUM:  r_eaddr <= sum;
                default: r_eaddr <= reg_val;
            endcase
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                OUT_REG: begin
                    r_op_addr <= {13'd0, reg_idx};
                    r_op_val  <= reg_val;
                    r_status  <= 1'b0;
                end
                OUT_MEM: begin
                    r_op_addr <= r_eaddr;
                    r_op_val  <= mem_data;
                    r_status  <= 1'b0;
                end
                default: begin
                    r_op_addr <= 16'd0;
                    r_op_val  <= 16'd0;
                    r_status  <= 1'b1;
                end
            endcase
        end
    end

    assign o_stat.mode       = r_spec[5:3];
    assign o_operand_address = r_op_addr;
    assign o_operand_value   = r_op_val;
    assign o_status          = r_status;

endmodule

FILE: rtl/core/oamr_ctrl.sv
// ----------------------------------------------------------------------------
// Operand address mode resolver controller
// Sequences accept, the first and second memory read and the result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "operand_address_mode_resolver_core_defines.svh"

module oamr_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_cmd,
    output logic               o_valid,
    input  logic               i_stall,
    input  oamr_pkg::t_dp_stat i_stat,
    output oamr_pkg::t_dp_cmd  o_cmd
);
    import oamr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FIRST  = 2'd1;
    localparam logic [1:0] S_SECOND = 2'd2;
    localparam logic [1:0] S_LAST   = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       accept;
    logic       out_free;
    t_dp_cmd    cmd;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_cmd == CMD_MEM_WR) begin
                        cmd.mem_wr = 1'b1;
                    end else if (i_cmd == CMD_REG_WR) begin
                        cmd.reg_wr = 1'b1;
                    end else if (i_cmd == CMD_RESOLVE) begin
                        cmd.capture = 1'b1;
                        n_state     = S_FIRST;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_FIRST: begin
                n_state = S_LAST;
                unique case (i_stat.mode)
                    MODE_DEFER, MODE_AUTOINC: begin
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RD_REG;
                        cmd.ea_load = 1'b1;
                        cmd.ea_sel  = EA_REG;
                        cmd.upd     = (i_stat.mode == MODE_AUTOINC) ? UPD_AUTO : UPD_NONE;
                    end
                    MODE_AUTOINC_DEFER: begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_REG;
                        cmd.upd    = UPD_TWO_R;
                        n_state    = S_SECOND;
                    end
                    MODE_INDEX: begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_PC;
                        cmd.upd    = UPD_TWO_PC;
                        n_state    = S_SECOND;
                    end
                    default: ;
                endcase
            end
            S_SECOND: begin
                n_state     = S_LAST;
                cmd.rd_en   = 1'b1;
                cmd.ea_load = 1'b1;
                if (i_stat.mode == MODE_INDEX) begin
                    cmd.rd_sel = RD_SUM;
                    cmd.ea_sel = EA_SUM;
                end else begin
                    cmd.rd_sel = RD_DATA;
                    cmd.ea_sel = EA_DATA;
                end
            end
            S_LAST: begin
                unique case (i_stat.mode)
                    MODE_REG:                      cmd.out_sel = OUT_REG;
                    MODE_DEFER, MODE_AUTOINC,
                    MODE_AUTOINC_DEFER, MODE_INDEX: cmd.out_sel = OUT_MEM;
                    default:                       cmd.out_sel = OUT_UNSUP;
                endcase
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign n_out_valid = cmd.out_load || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    `OAMR_ASSERT(a_load_has_room, i_clk, i_rst_n, cmd.out_load |-> (!r_out_valid || !i_stall), "result overwrites a pending beat")
    `OAMR_ASSERT(a_resolve_starts, i_clk, i_rst_n, (accept && i_cmd == CMD_RESOLVE) |=> (r_state == S_FIRST), "resolve beat did not start sequence")
    `OAMR_ASSERT_NEVER(a_rd_wr_clash, i_clk, i_rst_n, cmd.rd_en && cmd.mem_wr, "memory read and write in one cycle")
    `OAMR_ASSERT(a_second_after_first, i_clk, i_rst_n, (r_state == S_SECOND) |-> ($past(r_state) == S_FIRST), "second read without first")

endmodule

FILE: rtl/core/operand_address_mode_resolver_core.sv
// ----------------------------------------------------------------------------
// Operand address mode resolver core
// Load beats (memory or register write) are taken in idle and return nothing.
// Resolve beats pass through capture, a first step and the result step for
// modes 0, 1, 2, 4, 5, 7, plus a second read step for modes 3 and 6 (two
// dependent reads of the single-port word memory); new beats stall until the
// result is loaded and the core is idle again. An earlier result still stalled
// at the output holds the last step until it is taken.
// Synchronous active-low reset clears the register file and handshake state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module operand_address_mode_resolver_core #(
    parameter int unsigned MEM_WORDS = oamr_pkg::MEM_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_cmd,
    input  logic [5:0]  i_specifier,
    input  logic        i_byte_mode,
    input  logic [15:0] i_load_address,
    input  logic [2:0]  i_load_register,
    input  logic [15:0] i_load_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_operand_address,
    output logic [15:0] o_operand_value,
    output logic        o_status
);
    import oamr_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    oamr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_cmd   (i_cmd),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    oamr_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (dp_cmd),
        .o_stat            (dp_stat),
        .i_specifier       (i_specifier),
        .i_byte_mode       (i_byte_mode),
        .i_load_address    (i_load_address),
        .i_load_register   (i_load_register),
        .i_load_data       (i_load_data),
        .o_operand_address (o_operand_address),
        .o_operand_value   (o_operand_value),
        .o_status          (o_status)
    );

endmodule

FILE: tb/operand_address_mode_resolver_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Operand address mode resolver core testbench
// Sends load, resolve and no-op beats, mostly in bursts against a stalling
// receiver. It predicts the effective address, the operand value and the
// status from its own copy of the registers and the word memory, and checks
// every result beat in order.
// ----------------------------------------------------------------------------

module operand_address_mode_resolver_core_tb;
    import oamr_pkg::*;

    localparam int unsigned MEM_WORDS = MEM_WORDS_DEF;

    localparam logic [1:0] CMD_NOP      = 2'd3;
    localparam logic [2:0] MODE_RSVD_4  = 3'd4;
    localparam logic [2:0] MODE_RSVD_5  = 3'd5;
    localparam logic [2:0] MODE_RSVD_7  = 3'd7;
    localparam logic       STATUS_UNSUP = 1'b1;
    localparam int         MAX_REPORTS  = 10;

    typedef struct packed {
        logic [15:0] address;
        logic [15:0] value;
        logic        status;
    } t_operand;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [1:0]  i_cmd           = '0;
    logic [5:0]  i_specifier     = '0;
    logic        i_byte_mode     = 1'b0;
    logic [15:0] i_load_address  = '0;
    logic [2:0]  i_load_register = '0;
    logic [15:0] i_load_data     = '0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_operand_address;
    logic [15:0] o_operand_value;
    logic        o_status;

    logic [15:0] model_regs [8];
    logic [15:0] model_mem [MEM_WORDS];
    bit          model_written [MEM_WORDS];
    t_operand    expected_operands [$];

    int errors      = 0;
    int reports     = 0;
    int results_ok  = 0;
    int n_loads     = 0;
    int n_resolves  = 0;
    int n_unsup     = 0;
    int burst_left  = 0;
    bit tx_idle_en  = 1'b0;
    bit rx_stall_en = 1'b0;

    operand_address_mode_resolver_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_cmd             (i_cmd),
        .i_specifier       (i_specifier),
        .i_byte_mode       (i_byte_mode),
        .i_load_address    (i_load_address),
        .i_load_register   (i_load_register),
        .i_load_data       (i_load_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_operand_address (o_operand_address),
        .o_operand_value   (o_operand_value),
        .o_status          (o_status)
    );

    always begin
        #2;
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
    end

    function automatic logic [15:0] mem_word(input logic [15:0] addr);
        if (int'(addr[15:1]) >= MEM_WORDS) return 16'h0000;
        return model_mem[addr[15:1]];
    endfunction

    function automatic bit word_defined(input logic [15:0] addr);
        if (int'(addr[15:1]) >= MEM_WORDS) return 1'b1;
        return model_written[addr[15:1]];
    endfunction

    function automatic t_operand predict_operand(input logic [5:0] spec, input logic byte_op);
        t_operand    res;
        logic [2:0]  r;
        logic [15:0] disp;
        res = '0;
        r   = spec[2:0];
        case (spec[5:3])
            MODE_REG: begin
                res.address = {13'd0, r};
                res.value   = model_regs[r];
            end
            MODE_DEFER: begin
                res.address = model_regs[r];
                res.value   = mem_word(res.address);
            end
            MODE_AUTOINC: begin
                res.address = model_regs[r];
                res.value   = mem_word(res.address);
                if (byte_op && r != SP_REG && r != PC_REG) begin
                    model_regs[r] = model_regs[r] + 16'd1;
                end else begin
                    model_regs[r] = model_regs[r] + 16'd2;
                end
            end
            MODE_AUTOINC_DEFER: begin
                res.address   = mem_word(model_regs[r]);
                res.value     = mem_word(res.address);
                model_regs[r] = model_regs[r] + 16'd2;
            end
            MODE_INDEX: begin
                disp               = mem_word(model_regs[PC_REG]);
                model_regs[PC_REG] = model_regs[PC_REG] + 16'd2;
                res.address        = model_regs[r] + disp;
                res.value          = mem_word(res.address);
            end
            default: begin
                res.status = STATUS_UNSUP;
            end
        endcase
        return res;
    endfunction

    function automatic logic [15:0] rand_data();
        case ($urandom_range(0, 9))
            0: return 16'hFFFF;
            1: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 9))
            0, 1, 2: return 16'($urandom);
            3, 4: return 16'hFFFF - 16'($urandom_range(0, 15));
            5, 6: return 16'($urandom_range(0, 15));
            default: return 16'h1000 + 16'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [2:0] pick_mode();
        case ($urandom_range(0, 19))
            0, 1, 2, 3: return MODE_REG;
            4, 5, 6: return MODE_DEFER;
            7, 8, 9, 10: return MODE_AUTOINC;
            11, 12, 13: return MODE_AUTOINC_DEFER;
            14, 15, 16, 17: return MODE_INDEX;
            18: return ($urandom_range(0, 1) == 0) ? MODE_RSVD_4 : MODE_RSVD_5;
            default: return MODE_RSVD_7;
        endcase
    endfunction

    task automatic send_beat(input logic [1:0] cmd, input logic [5:0] spec,
                             input logic byte_op, input logic [15:0] ld_addr,
                             input logic [2:0] ld_reg, input logic [15:0] ld_data);
        int       gap;
        t_operand res;
        if (tx_idle_en && burst_left == 0) begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 5);
            burst_left = $urandom_range(1, 16);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_specifier     <= spec;
        i_byte_mode     <= byte_op;
        i_load_address  <= ld_addr;
        i_load_register <= ld_reg;
        i_load_data     <= ld_data;
        do @(posedge i_clk); while (o_stall);
        case (cmd)
            CMD_MEM_WR: begin
                if (int'(ld_addr[15:1]) < MEM_WORDS) begin
                    model_mem[ld_addr[15:1]]     = ld_data;
                    model_written[ld_addr[15:1]] = 1'b1;
                end
                n_loads++;
            end
            CMD_REG_WR: begin
                model_regs[ld_reg] = ld_data;
                n_loads++;
            end
            CMD_RESOLVE: begin
                res = predict_operand(spec, byte_op);
                expected_operands.push_back(res);
                n_resolves++;
                if (res.status == STATUS_UNSUP) n_unsup++;
            end
            default: ;
        endcase
    endtask

    task automatic load_mem(input logic [15:0] addr, input logic [15:0] data);
        send_beat(CMD_MEM_WR, 6'($urandom), 1'($urandom), addr, 3'($urandom), data);
    endtask

    task automatic load_reg(input logic [2:0] r, input logic [15:0] data);
        send_beat(CMD_REG_WR, 6'($urandom), 1'($urandom), 16'($urandom), r, data);
    endtask

    task automatic define_word(input logic [15:0] addr);
        if (!word_defined(addr)) begin
            load_mem({addr[15:1], 1'($urandom)}, rand_data());
        end
    endtask

    // fill every word the resolve will read that holds no data yet
    task automatic cover_reads(input logic [5:0] spec);
        logic [2:0]  r;
        logic [15:0] ptr;
        logic [15:0] base;
        logic [15:0] target;
        r = spec[2:0];
        case (spec[5:3])
            MODE_DEFER, MODE_AUTOINC: begin
                define_word(model_regs[r]);
            end
            MODE_AUTOINC_DEFER: begin
                define_word(model_regs[r]);
                ptr = mem_word(model_regs[r]);
                define_word(ptr);
            end
            MODE_INDEX: begin
                ptr = model_regs[PC_REG];
                define_word(ptr);
                base   = (r == PC_REG) ? ptr + 16'd2 : model_regs[r];
                target = base + mem_word(ptr);
                define_word(target);
            end
            default: ;
        endcase
    endtask

    task automatic resolve(input logic [5:0] spec, input logic byte_op);
        cover_reads(spec);
        send_beat(CMD_RESOLVE, spec, byte_op, 16'($urandom), 3'($urandom), 16'($urandom));
    endtask

    task automatic run_scenario();
        logic [2:0]  r;
        logic [2:0]  rs;
        logic [15:0] base;
        int          words;
        int          ops;
        int          i;
        r    = 3'($urandom_range(0, 7));
        base = pick_address();
        load_reg(r, base);
        words = $urandom_range(0, 4);
        for (i = 0; i < words; i++) begin
            load_mem((base + 16'(2 * i)) ^ 16'($urandom_range(0, 1)), rand_data());
        end
        if ($urandom_range(0, 2) == 0) load_reg(PC_REG, pick_address());
        ops = $urandom_range(1, 5);
        for (i = 0; i < ops; i++) begin
            rs = ($urandom_range(0, 3) != 0) ? r : 3'($urandom_range(0, 7));
            resolve({pick_mode(), rs}, 1'($urandom));
        end
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0: send_beat(CMD_NOP, 6'($urandom), 1'($urandom), 16'($urandom),
                         3'($urandom), 16'($urandom));
            1: load_reg(3'($urandom), rand_data());
            2: load_mem(pick_address(), rand_data());
            default: resolve(6'($urandom), 1'($urandom));
        endcase
    endtask

    task automatic test_reset_state();
        resolve({MODE_REG, 3'd0}, 1'b0);
        resolve({MODE_REG, SP_REG}, 1'b0);
        resolve({MODE_REG, PC_REG}, 1'b1);
    endtask

    task automatic test_unsupported_and_noop();
        resolve({MODE_RSVD_4, PC_REG}, 1'b0);
        resolve({MODE_RSVD_5, 3'd0}, 1'b1);
        resolve({MODE_RSVD_7, SP_REG}, 1'b1);
        send_beat(CMD_NOP, 6'h3F, 1'b1, 16'hFFFF, 3'h7, 16'hFFFF);
    endtask

    task automatic test_word_alignment();
        load_mem(16'h1235, 16'hA5A5);
        load_reg(3'd1, 16'h1234);
        load_reg(3'd2, 16'h1235);
        resolve({MODE_DEFER, 3'd1}, 1'b0);
        resolve({MODE_DEFER, 3'd2}, 1'b0);
        load_mem(16'hFFFF, 16'hFFFF);
        load_reg(3'd4, 16'hFFFE);
        resolve({MODE_DEFER, 3'd4}, 1'b0);
    endtask

    task automatic test_autoincrement();
        load_reg(3'd3, 16'hFFFF);
        resolve({MODE_AUTOINC, 3'd3}, 1'b1);
        resolve({MODE_REG, 3'd3}, 1'b0);
        load_reg(SP_REG, 16'h2000);
        resolve({MODE_AUTOINC, SP_REG}, 1'b1);
        load_reg(PC_REG, 16'h3001);
        resolve({MODE_AUTOINC, PC_REG}, 1'b1);
        resolve({MODE_AUTOINC, 3'd5}, 1'b0);
        resolve({MODE_REG, PC_REG}, 1'b0);
    endtask

    task automatic test_deferred_and_index();
        load_reg(3'd0, 16'hFFFE);
        resolve({MODE_AUTOINC_DEFER, 3'd0}, 1'b0);
        load_reg(PC_REG, 16'h4000);
        load_mem(16'h4000, 16'h0010);
        resolve({MODE_INDEX, PC_REG}, 1'b0);
        load_mem(16'h4002, 16'hFFFF);
        load_reg(3'd5, 16'h0001);
        resolve({MODE_INDEX, 3'd5}, 1'b1);
        resolve({MODE_AUTOINC_DEFER, PC_REG}, 1'b1);
    endtask

    task automatic test_random_traffic(input int quota, input bit tx_idle, input bit rx_stall);
        int start;
        start       = n_loads + n_resolves;
        tx_idle_en  = tx_idle;
        rx_stall_en <= rx_stall;
        while (n_loads + n_resolves - start < quota) begin
            if ($urandom_range(0, 9) < 8) run_scenario();
            else send_noise();
        end
    endtask

    task automatic test_drain_pause();
        repeat (3) begin
            run_scenario();
            i_valid <= 1'b0;
            do @(posedge i_clk); while (expected_operands.size() != 0);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_operand got;
        t_operand want;
        int       rx_run;
        bit       rx_stalling;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_operand_address, o_operand_value, o_status};
            if (expected_operands.size() == 0) begin
                errors++;
                if (reports < MAX_REPORTS) begin
                    reports++;
                    $display("unexpected result beat: addr %h value %h status %b",
                             got.address, got.value, got.status);
                end
            end else begin
                want = expected_operands.pop_front();
                if (got.address !== want.address || got.value !== want.value ||
                    got.status !== want.status) begin
                    errors++;
                    if (reports < MAX_REPORTS) begin
                        reports++;
                        $write("mismatch: expected addr %h value %h status %b, ",
                               want.address, want.value, want.status);
                        $display("got addr %h value %h status %b",
                                 got.address, got.value, got.status);
                    end
                end else begin
                    results_ok++;
                end
            end
        end
        if (!i_rst_n || !rx_stall_en) begin
            i_stall <= 1'b0;
            rx_run      = 0;
            rx_stalling = 1'b0;
        end else if (rx_run > 0) begin
            rx_run--;
        end else begin
            rx_stalling = !rx_stalling;
            if (rx_stalling) begin
                rx_run = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 14)
                                                     : $urandom_range(0, 3);
            end else begin
                rx_run = $urandom_range(0, 9);
            end
            i_stall <= rx_stalling;
        end
    end

    initial begin
        int drain_cycles;
        foreach (model_regs[i]) model_regs[i] = 16'h0000;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_state();
        test_unsupported_and_noop();
        test_word_alignment();
        test_autoincrement();
        test_deferred_and_index();
        test_random_traffic(900, 1'b1, 1'b1);
        test_drain_pause();
        test_random_traffic(300, 1'b0, 1'b0);
        test_random_traffic(550, 1'b1, 1'b1);
        i_valid <= 1'b0;
        drain_cycles = 0;
        while (expected_operands.size() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (20) @(posedge i_clk);
        @(negedge i_clk);
        if (expected_operands.size() != 0) begin
            errors++;
            $display("%0d expected result beats never arrived", expected_operands.size());
        end
        $display("covered %0d load beats and %0d resolve beats (%0d with reserved modes)",
                 n_loads, n_resolves, n_unsup);
        $display("%0d result beats matched, %0d errors", results_ok, errors);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: operand_address_mode_resolver_core.f
+incdir+rtl/core
rtl/core/oamr_pkg.sv
rtl/core/oamr_datapath.sv
rtl/core/oamr_ctrl.sv
rtl/core/operand_address_mode_resolver_core.sv
tb/operand_address_mode_resolver_core_tb.sv
